// ===== rtl/nrb_pkg.sv =====
// shared types, constants and helpers for the network controller register block
`default_nettype none
package nrb_pkg;

    localparam int unsigned PMEM_START = 16384;
    localparam int unsigned PMEM_SIZE  = 32768;
    localparam int unsigned PMEM_END   = PMEM_START + PMEM_SIZE;
    localparam int unsigned PMEM_AW    = $clog2(PMEM_SIZE);
    localparam int unsigned MAX_FRAME  = 1514;
    localparam int unsigned PROM_DEPTH = 32;
    localparam int unsigned PROM_AW    = $clog2(PROM_DEPTH);
    localparam int unsigned OUTQ_DEPTH = 4;
    localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUTQ_CW    = OUTQ_AW + 1;

    localparam logic [7:0] CMD_RESET_VAL = 8'h21;
    localparam logic [7:0] ISR_RESET_VAL = 8'h80;
    localparam logic [7:0] PROM_SIG      = 8'h57;
    localparam logic [7:0] ISR_ACK_MASK  = 8'h7f;
    localparam logic [7:0] CRDA_LO_VAL   = 8'h50;
    localparam logic [7:0] CRDA_HI_VAL   = 8'h70;
    localparam logic [7:0] CFG_RO_VAL    = 8'h40;
    localparam logic [7:0] UNMAPPED_VAL  = 8'hff;

    // action codes
    localparam logic [2:0] ACT_REG_WR   = 3'd0;
    localparam logic [2:0] ACT_REG_RD   = 3'd1;
    localparam logic [2:0] ACT_DATA_WR  = 3'd2;
    localparam logic [2:0] ACT_DATA_RD  = 3'd3;
    localparam logic [2:0] ACT_RESET_RD = 3'd4;
    localparam logic [2:0] ACT_RX_BYTE  = 3'd5;

    // rx status codes
    localparam logic [1:0] RXS_OK      = 2'd0;
    localparam logic [1:0] RXS_STOPPED = 2'd1;
    localparam logic [1:0] RXS_FULL    = 2'd2;

    // paged register offsets {page, offset}
    localparam logic [5:0] OFF_PSTART = 6'h01;
    localparam logic [5:0] OFF_PSTOP  = 6'h02;
    localparam logic [5:0] OFF_BNRY   = 6'h03;
    localparam logic [5:0] OFF_TPSR   = 6'h04;
    localparam logic [5:0] OFF_TBCR0  = 6'h05;
    localparam logic [5:0] OFF_TBCR1  = 6'h06;
    localparam logic [5:0] OFF_ISR    = 6'h07;
    localparam logic [5:0] OFF_RSAR0  = 6'h08;
    localparam logic [5:0] OFF_RSAR1  = 6'h09;
    localparam logic [5:0] OFF_RBCR0  = 6'h0a;
    localparam logic [5:0] OFF_RBCR1  = 6'h0b;
    localparam logic [5:0] OFF_RCR    = 6'h0c;
    localparam logic [5:0] OFF_DCR    = 6'h0e;
    localparam logic [5:0] OFF_IMR    = 6'h0f;
    localparam logic [5:0] OFF_PAR0   = 6'h11;
    localparam logic [5:0] OFF_PAR5   = 6'h16;
    localparam logic [5:0] OFF_CURR   = 6'h17;
    localparam logic [5:0] OFF_MAR0   = 6'h18;
    localparam logic [5:0] OFF_MAR7   = 6'h1f;
    localparam logic [5:0] OFF_PSTART_RD = 6'h21;
    localparam logic [5:0] OFF_PSTOP_RD  = 6'h22;
    localparam logic [5:0] OFF_EEPROM = 6'h31;
    localparam logic [5:0] OFF_CFG3   = 6'h35;
    localparam logic [5:0] OFF_CFG4   = 6'h36;

    typedef enum logic [1:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_HDR,
        SEQ_DATA
    } seq_state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  reg_offset;
        logic [7:0]  write_data;
        logic [7:0]  rx_byte;
        logic        rx_first;
        logic        rx_last;
        logic [10:0] rx_frame_len;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq;
        logic        tx_request;
        logic [15:0] tx_start_addr;
        logic [15:0] tx_length;
        logic [1:0]  rx_status;
    } out_item_t;

    typedef struct packed {
        logic               we;
        logic [PMEM_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [PMEM_AW-1:0] raddr;
    } mem_req_t;

    typedef logic [PROM_DEPTH-1:0][7:0] prom_t;

    function automatic prom_t prom_image(input logic [47:0] mac);
        prom_t p;
        p = '0;
        for (int i = 0; i < 6; i++) begin
            p[2*i]   = mac[40-8*i +: 8];
            p[2*i+1] = mac[40-8*i +: 8];
        end
        for (int i = 28; i < PROM_DEPTH; i++) begin
            p[i] = PROM_SIG;
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ne2000_nic_register_block_unit.sv =====
// top level: 8390-style network controller register block
// register, data port and plain receive requests: one per cycle while s_ready is high
// first byte of a stored frame: busy in SEQ_HDR, then SEQ_DATA, for the ring header writes
// reset read: clearing pass over all 32768 packet memory bytes, no requests taken meanwhile
// aresetn (synchronous, active low) also starts the clearing pass
// rate is set by the single write port of the packet memory
`default_nettype none
module ne2000_nic_register_block_unit
    import nrb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [47:0] cfg_wr_data
);

    mem_req_t   mem_req;
    logic [7:0] mem_rdata;
    logic       space_ok;
    logic       s1_busy;
    logic       push;
    out_item_t  push_data;

    nrb_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .space_ok    (space_ok),
        .s1_busy     (s1_busy),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .push        (push),
        .push_data   (push_data)
    );

    nrb_pmem u_pmem (
        .aclk      (aclk),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    nrb_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pending   (s1_busy),
        .space_ok  (space_ok),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// ===== rtl/nrb_pmem.sv =====
// packet memory, one write port and one registered read port
`default_nettype none
module nrb_pmem
    import nrb_pkg::*;
(
    input  wire logic     aclk,
    input  wire mem_req_t mem_req,
    output logic [7:0]    mem_rdata
);

    logic [7:0] mem_array [PMEM_SIZE];

    always_ff @(posedge aclk) begin
        if (mem_req.we) begin
            mem_array[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re) begin
            mem_rdata <= mem_array[mem_req.raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/nrb_outq.sv =====
// result queue between the core and the result channel
`default_nettype none
module nrb_outq
    import nrb_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire out_item_t push_data,
    input  wire logic      pending,
    output logic           space_ok,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    out_item_t            q_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]   wr_ptr_reg;
    logic [OUTQ_AW-1:0]   rd_ptr_reg;
    logic [OUTQ_CW-1:0]   count_reg;
    logic                 pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign m_data   = q_reg[rd_ptr_reg];
    assign space_ok = ((count_reg + OUTQ_CW'(pending)) < OUTQ_CW'(OUTQ_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + OUTQ_CW'(push) - OUTQ_CW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/nrb_core.sv =====
// register file, request decode, receive ring logic and memory sequencer
`default_nettype none
module nrb_core
    import nrb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [47:0] cfg_wr_data,
    input  wire logic        space_ok,
    output logic             s1_busy,
    output mem_req_t         mem_req,
    input  wire logic [7:0]  mem_rdata,
    output logic             push,
    output out_item_t        push_data
);

    logic [47:0] mac_reg;
    logic [7:0]  cmd_reg, cmd_next, isr_reg, isr_next, imr_reg, imr_next;
    logic [7:0]  tsr_reg, tsr_next, rsr_reg, rsr_next, rxcr_reg, rxcr_next;
    logic [7:0]  dcfg_reg, dcfg_next, eeprom_reg, eeprom_next;
    logic [15:0] rstart_reg, rstart_next, rstop_reg, rstop_next;
    logic [7:0]  bnry_reg, bnry_next, curpg_reg, curpg_next, tpsr_reg, tpsr_next;
    logic [15:0] tcnt_reg, tcnt_next, rsar_reg, rsar_next, rcnt_reg, rcnt_next;
    logic [7:0]  phys_reg [6];
    logic [7:0]  phys_next [6];
    logic [7:0]  mcast_reg [8];
    logic [7:0]  mcast_next [8];
    prom_t       prom_reg, prom_next;
    logic [15:0] rx_wptr_reg, rx_wptr_next, rx_naddr_reg, rx_naddr_next;
    logic        rx_active_reg, rx_active_next;

    seq_state_t         state_reg, state_next;
    logic [PMEM_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0]         hcnt_reg, hcnt_next;
    logic [15:0]        hbase_reg, hbase_next;
    logic [7:0]         hdr1_reg, hdr1_next, hdr2_reg, hdr2_next, hdr3_reg, hdr3_next;
    logic               dw_en_reg, dw_en_next;
    logic [15:0]        dw_addr_reg, dw_addr_next;
    logic [7:0]         dw_data_reg, dw_data_next;

    logic       s1_valid_reg;
    out_item_t  s1_res_reg, res;
    logic       s1_mem_reg, use_mem;

    logic        accept;
    logic [5:0]  off;
    logic        wr_en;
    logic [15:0] wr_addr, pidx, a16, wp;
    logic [7:0]  wr_data, wd;
    logic [16:0] tx_idx;
    logic [17:0] tx_sum;
    logic        full;
    logic [15:0] ridx, rbnd;
    logic signed [17:0] avail;
    logic [15:0] idx;
    logic [11:0] total;
    logic [12:0] rnd;
    logic [16:0] nxt;
    logic        active;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == SEQ_IDLE) && space_ok;
    assign s1_busy = s1_valid_reg;
    assign off     = {cmd_reg[7:6], s_data.reg_offset};
    assign wd      = s_data.write_data;

    // ring space check for a new frame
    always_comb begin
        ridx  = {curpg_reg, 8'h00};
        rbnd  = {bnry_reg, 8'h00};
        avail = '0;
        if (ridx < rbnd) begin
            avail = 18'({2'b00, rbnd} - {2'b00, ridx});
        end else begin
            avail = 18'({2'b00, rstop_reg - rstart_reg} - {2'b00, ridx - rbnd});
        end
        full = (rstop_reg <= rstart_reg) || (avail < $signed(18'(MAX_FRAME + 4)));
    end

    always_comb begin
        cmd_next = cmd_reg; isr_next = isr_reg; imr_next = imr_reg;
        tsr_next = tsr_reg; rsr_next = rsr_reg; rxcr_next = rxcr_reg;
        dcfg_next = dcfg_reg; eeprom_next = eeprom_reg;
        rstart_next = rstart_reg; rstop_next = rstop_reg;
        bnry_next = bnry_reg; curpg_next = curpg_reg; tpsr_next = tpsr_reg;
        tcnt_next = tcnt_reg; rsar_next = rsar_reg; rcnt_next = rcnt_reg;
        phys_next = phys_reg; mcast_next = mcast_reg; prom_next = prom_reg;
        rx_wptr_next = rx_wptr_reg; rx_naddr_next = rx_naddr_reg;
        rx_active_next = rx_active_reg;
        state_next = state_reg; clr_cnt_next = clr_cnt_reg; hcnt_next = hcnt_reg;
        hbase_next = hbase_reg; hdr1_next = hdr1_reg; hdr2_next = hdr2_reg;
        hdr3_next = hdr3_reg; dw_en_next = dw_en_reg; dw_addr_next = dw_addr_reg;
        dw_data_next = dw_data_reg;
        res = '0; use_mem = 1'b0;
        wr_en = 1'b0; wr_addr = '0; wr_data = '0;
        mem_req = '0;
        tx_idx = '0; tx_sum = '0; a16 = '0; wp = rx_wptr_reg;
        idx = '0; total = '0; rnd = '0; nxt = '0; active = rx_active_reg;
        pidx = '0;

        case (state_reg)
            SEQ_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_cnt_reg;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg) begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_HDR: begin
                wr_en   = 1'b1;
                wr_addr = hbase_reg + {14'd0, hcnt_reg};
                case (hcnt_reg)
                    2'd1:    wr_data = hdr1_reg;
                    2'd2:    wr_data = hdr2_reg;
                    default: wr_data = hdr3_reg;
                endcase
                hcnt_next = hcnt_reg + 1'b1;
                if (hcnt_reg == 2'd3) begin
                    state_next = SEQ_DATA;
                end
            end
            SEQ_DATA: begin
                wr_en      = dw_en_reg;
                wr_addr    = dw_addr_reg;
                wr_data    = dw_data_reg;
                state_next = SEQ_IDLE;
            end
            default: begin
                if (accept) begin
                    case (s_data.action)
                        ACT_REG_WR: begin
                            if (s_data.reg_offset == 4'd0) begin
                                cmd_next = wd;
                                if (!wd[0]) begin
                                    isr_next[7] = 1'b0;
                                    if ((wd[4] || wd[3]) && rcnt_reg == 16'd0) begin
                                        isr_next[6] = 1'b1;
                                    end
                                    if (wd[2]) begin
                                        tx_idx = {1'b0, tpsr_reg, 8'h00};
                                        if (tx_idx >= 17'(PMEM_END)) begin
                                            tx_idx = tx_idx - 17'(PMEM_SIZE);
                                        end
                                        tx_sum = {1'b0, tx_idx} + {2'b00, tcnt_reg};
                                        if (tx_sum <= 18'(PMEM_END)) begin
                                            res.tx_request    = 1'b1;
                                            res.tx_start_addr = tx_idx[15:0];
                                            res.tx_length     = tcnt_reg;
                                        end
                                        tsr_next    = 8'h01;
                                        isr_next[1] = 1'b1;
                                        cmd_next[2] = 1'b0;
                                    end
                                end
                            end else begin
                                case (off)
                                    OFF_PSTART: if ({1'b0, wd, 8'h00} <= 17'(PMEM_END))
                                        rstart_next = {wd, 8'h00};
                                    OFF_PSTOP: if ({1'b0, wd, 8'h00} <= 17'(PMEM_END))
                                        rstop_next = {wd, 8'h00};
                                    OFF_BNRY: if ({1'b0, wd, 8'h00} < 17'(PMEM_END))
                                        bnry_next = wd;
                                    OFF_TPSR:  tpsr_next = wd;
                                    OFF_TBCR0: tcnt_next = {tcnt_reg[15:8], wd};
                                    OFF_TBCR1: tcnt_next = {wd, tcnt_reg[7:0]};
                                    OFF_ISR:   isr_next = isr_reg & ~(wd & ISR_ACK_MASK);
                                    OFF_RSAR0: rsar_next = {rsar_reg[15:8], wd};
                                    OFF_RSAR1: rsar_next = {wd, rsar_reg[7:0]};
                                    OFF_RBCR0: rcnt_next = {rcnt_reg[15:8], wd};
                                    OFF_RBCR1: rcnt_next = {wd, rcnt_reg[7:0]};
                                    OFF_RCR:   rxcr_next = wd;
                                    OFF_DCR:   dcfg_next = wd;
                                    OFF_IMR:   imr_next = wd;
                                    OFF_CURR: if ({1'b0, wd, 8'h00} < 17'(PMEM_END))
                                        curpg_next = wd;
                                    OFF_EEPROM: eeprom_next = {wd[7:1], eeprom_reg[0]};
                                    default: begin
                                        if (off >= OFF_PAR0 && off <= OFF_PAR5) begin
                                            phys_next[3'(off[2:0] - 3'd1)] = wd;
                                        end else if (off >= OFF_MAR0 && off <= OFF_MAR7) begin
                                            mcast_next[off[2:0]] = wd;
                                        end
                                    end
                                endcase
                            end
                        end
                        ACT_REG_RD: begin
                            if (s_data.reg_offset == 4'd0) begin
                                res.read_data = cmd_reg;
                            end else begin
                                case (off)
                                    OFF_BNRY:      res.read_data = bnry_reg;
                                    OFF_TPSR:      res.read_data = tsr_reg;
                                    OFF_ISR:       res.read_data = isr_reg;
                                    OFF_RSAR0:     res.read_data = rsar_reg[7:0];
                                    OFF_RSAR1:     res.read_data = rsar_reg[15:8];
                                    OFF_RBCR0:     res.read_data = CRDA_LO_VAL;
                                    OFF_RBCR1:     res.read_data = CRDA_HI_VAL;
                                    OFF_RCR:       res.read_data = rsr_reg;
                                    OFF_CURR:      res.read_data = curpg_reg;
                                    OFF_PSTART_RD: res.read_data = rstart_reg[15:8];
                                    OFF_PSTOP_RD:  res.read_data = rstop_reg[15:8];
                                    OFF_EEPROM:    res.read_data = eeprom_reg;
                                    OFF_CFG3:      res.read_data = CFG_RO_VAL;
                                    OFF_CFG4:      res.read_data = CFG_RO_VAL;
                                    default: begin
                                        if (off >= OFF_PAR0 && off <= OFF_PAR5) begin
                                            res.read_data = phys_reg[3'(off[2:0] - 3'd1)];
                                        end else if (off >= OFF_MAR0 && off <= OFF_MAR7) begin
                                            res.read_data = mcast_reg[off[2:0]];
                                        end
                                    end
                                endcase
                            end
                        end
                        ACT_DATA_WR, ACT_DATA_RD: begin
                            if (s_data.action == ACT_DATA_RD) begin
                                if (rsar_reg < 16'(PROM_DEPTH)) begin
                                    res.read_data = prom_reg[rsar_reg[PROM_AW-1:0]];
                                end else if (rsar_reg >= 16'(PMEM_START) &&
                                             {1'b0, rsar_reg} < 17'(PMEM_END)) begin
                                    pidx          = rsar_reg - 16'(PMEM_START);
                                    use_mem       = 1'b1;
                                    mem_req.re    = 1'b1;
                                    mem_req.raddr = pidx[PMEM_AW-1:0];
                                end else begin
                                    res.read_data = UNMAPPED_VAL;
                                end
                            end else if (rcnt_reg != 16'd0) begin
                                wr_en   = 1'b1;
                                wr_addr = rsar_reg;
                                wr_data = wd;
                            end
                            if (s_data.action == ACT_DATA_RD || rcnt_reg != 16'd0) begin
                                a16 = rsar_reg + 16'd1;
                                if (a16 == rstop_reg) begin
                                    a16 = rstart_reg;
                                end
                                rsar_next = a16;
                                if (rcnt_reg <= 16'd1) begin
                                    rcnt_next   = '0;
                                    isr_next[6] = 1'b1;
                                end else begin
                                    rcnt_next = rcnt_reg - 16'd1;
                                end
                            end
                        end
                        ACT_RESET_RD: begin
                            cmd_next = CMD_RESET_VAL; isr_next = ISR_RESET_VAL; imr_next = '0;
                            tsr_next = '0; rsr_next = '0; rxcr_next = '0; dcfg_next = '0;
                            eeprom_next = '0; rstart_next = '0; rstop_next = '0;
                            bnry_next = '0; curpg_next = '0; tpsr_next = '0;
                            tcnt_next = '0; rsar_next = '0; rcnt_next = '0;
                            phys_next = '{default: '0}; mcast_next = '{default: '0};
                            prom_next = prom_image(mac_reg);
                            rx_wptr_next = '0; rx_naddr_next = '0; rx_active_next = 1'b0;
                            state_next = SEQ_CLEAR; clr_cnt_next = '0;
                        end
                        ACT_RX_BYTE: begin
                            if (s_data.rx_first) begin
                                active = 1'b0;
                                if (cmd_reg[0]) begin
                                    res.rx_status = RXS_STOPPED;
                                end else if (full) begin
                                    res.rx_status = RXS_FULL;
                                end else begin
                                    rxcr_next[4] = 1'b1;
                                    idx = {curpg_reg, 8'h00};
                                    if ({1'b0, idx} >= 17'(PMEM_END)) begin
                                        idx = rstart_reg;
                                    end
                                    total = {1'b0, s_data.rx_frame_len} + 12'd4;
                                    rnd   = ({1'b0, total} + 13'd259) & 13'h1f00;
                                    nxt   = {1'b0, idx} + {4'd0, rnd};
                                    if (nxt >= {1'b0, rstop_reg}) begin
                                        nxt = nxt - {1'b0, rstop_reg - rstart_reg};
                                    end
                                    rsr_next      = {2'b00, s_data.rx_byte[0], 5'b00001};
                                    rx_naddr_next = nxt[15:0];
                                    wp            = idx + 16'd4;
                                    active        = 1'b1;
                                    wr_en         = 1'b1;
                                    wr_addr       = idx;
                                    wr_data       = rsr_next;
                                    hbase_next    = idx;
                                    hdr1_next     = nxt[15:8];
                                    hdr2_next     = total[7:0];
                                    hdr3_next     = {4'd0, total[11:8]};
                                    hcnt_next     = 2'd1;
                                    state_next    = SEQ_HDR;
                                    dw_en_next    = 1'b0;
                                end
                            end
                            if (active) begin
                                if (wp == rstop_reg) begin
                                    wp = rstart_reg;
                                end
                                if (wp < rstop_reg) begin
                                    if (state_next == SEQ_HDR) begin
                                        dw_en_next   = 1'b1;
                                        dw_addr_next = wp;
                                        dw_data_next = s_data.rx_byte;
                                    end else begin
                                        wr_en   = 1'b1;
                                        wr_addr = wp;
                                        wr_data = s_data.rx_byte;
                                    end
                                    wp = wp + 16'd1;
                                    if (wp == rstop_reg) begin
                                        wp = rstart_reg;
                                    end
                                end
                                rx_wptr_next = wp;
                                if (s_data.rx_last) begin
                                    curpg_next  = rx_naddr_next[15:8];
                                    isr_next[0] = 1'b1;
                                    active      = 1'b0;
                                end
                            end
                            rx_active_next = active;
                        end
                        default: begin
                        end
                    endcase
                    res.irq = ((isr_next & imr_next & ISR_ACK_MASK) != 8'h00);
                end
            end
        endcase

        // byte write decode onto prom or packet memory
        if (wr_en) begin
            if (wr_addr < 16'(PROM_DEPTH)) begin
                prom_next[wr_addr[PROM_AW-1:0]] = wr_data;
            end else if (wr_addr >= 16'(PMEM_START) && {1'b0, wr_addr} < 17'(PMEM_END)) begin
                pidx          = wr_addr - 16'(PMEM_START);
                mem_req.we    = 1'b1;
                mem_req.waddr = pidx[PMEM_AW-1:0];
                mem_req.wdata = wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SEQ_CLEAR;
            clr_cnt_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            mac_reg        <= '0;
            cmd_reg        <= CMD_RESET_VAL;
            isr_reg        <= ISR_RESET_VAL;
            imr_reg        <= '0;
            tsr_reg        <= '0;
            rsr_reg        <= '0;
            rxcr_reg       <= '0;
            dcfg_reg       <= '0;
            eeprom_reg     <= '0;
            rstart_reg     <= '0;
            rstop_reg      <= '0;
            bnry_reg       <= '0;
            curpg_reg      <= '0;
            tpsr_reg       <= '0;
            tcnt_reg       <= '0;
            rsar_reg       <= '0;
            rcnt_reg       <= '0;
            phys_reg       <= '{default: '0};
            mcast_reg      <= '{default: '0};
            prom_reg       <= prom_image(48'd0);
            rx_wptr_reg    <= '0;
            rx_naddr_reg   <= '0;
            rx_active_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            s1_valid_reg   <= accept;
            if (cfg_wr_en) begin
                mac_reg <= cfg_wr_data;
            end
            cmd_reg        <= cmd_next;
            isr_reg        <= isr_next;
            imr_reg        <= imr_next;
            tsr_reg        <= tsr_next;
            rsr_reg        <= rsr_next;
            rxcr_reg       <= rxcr_next;
            dcfg_reg       <= dcfg_next;
            eeprom_reg     <= eeprom_next;
            rstart_reg     <= rstart_next;
            rstop_reg      <= rstop_next;
            bnry_reg       <= bnry_next;
            curpg_reg      <= curpg_next;
            tpsr_reg       <= tpsr_next;
            tcnt_reg       <= tcnt_next;
            rsar_reg       <= rsar_next;
            rcnt_reg       <= rcnt_next;
            phys_reg       <= phys_next;
            mcast_reg      <= mcast_next;
            prom_reg       <= prom_next;
            rx_wptr_reg    <= rx_wptr_next;
            rx_naddr_reg   <= rx_naddr_next;
            rx_active_reg  <= rx_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        hcnt_reg    <= hcnt_next;
        hbase_reg   <= hbase_next;
        hdr1_reg    <= hdr1_next;
        hdr2_reg    <= hdr2_next;
        hdr3_reg    <= hdr3_next;
        dw_en_reg   <= dw_en_next;
        dw_addr_reg <= dw_addr_next;
        dw_data_reg <= dw_data_next;
        s1_res_reg  <= res;
        s1_mem_reg  <= use_mem;
    end

    // packet memory read data joins the result in the cycle after the request
    always_comb begin
        push      = s1_valid_reg;
        push_data = s1_res_reg;
        if (s1_mem_reg) begin
            push_data.read_data = mem_rdata;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/nrb_checker.sv =====
// port-level checks for the register block, bound to the top level
`default_nettype none
module nrb_checker
    import nrb_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire in_item_t    s_data,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire out_item_t   m_data
);

    // clearing pass holds off requests right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        disable iff (!aresetn) !$past(aresetn) |-> !s_ready)
        else $error("request taken during clearing pass");

    a_clear_after_reset_read: assert property (@(posedge aclk)
        disable iff (!aresetn)
        (s_valid && s_ready && s_data.action == ACT_RESET_RD) |=> !s_ready)
        else $error("request taken after reset read");

    a_tx_fields_zero: assert property (@(posedge aclk)
        disable iff (!aresetn)
        (m_valid && !m_data.tx_request) |->
            (m_data.tx_start_addr == 16'd0 && m_data.tx_length == 16'd0))
        else $error("transmit fields set without a transmit request");

    a_rx_status_code: assert property (@(posedge aclk)
        disable iff (!aresetn) m_valid |-> m_data.rx_status != 2'd3)
        else $error("bad rx status code");

    a_result_holds: assert property (@(posedge aclk)
        disable iff (!aresetn) (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped or changed while stalled");

endmodule

bind ne2000_nic_register_block_unit nrb_checker u_nrb_checker (.*);
`default_nettype wire
